FILE: src/market_feed_message_parser_macros.svh
// Assertion macros for the market feed message parser.
`ifndef MARKET_FEED_MESSAGE_PARSER_MACROS_SVH
`define MARKET_FEED_MESSAGE_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MFP_ASSERT_IMPL(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MFP_ASSERT_RESET(label, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MFP_ASSERT_IMPL(label, prop)
`define MFP_ASSERT_RESET(label, prop)
`endif
`endif

FILE: src/mfp_pkg.sv
// Shared types, constants and layout tables of the market feed message parser.
`default_nettype none
package mfp_pkg;

    localparam int MAX_MESSAGE_BYTES = 64;
    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

    // Kinds of field handling.
    localparam logic [2:0] K_TEXT  = 3'd0;
    localparam logic [2:0] K_N32   = 3'd1;
    localparam logic [2:0] K_N64   = 3'd2;
    localparam logic [2:0] K_PRICE = 3'd3;
    localparam logic [2:0] K_SKIP  = 3'd4;
    localparam logic [2:0] K_BODY  = 3'd5;
    localparam logic [2:0] K_TYPE  = 3'd6;

    // Entry identifiers with special meaning.
    localparam logic [4:0] E_NONE   = 5'd0;
    localparam logic [4:0] E_BODY   = 5'd22;
    localparam logic [4:0] E_STAMP2 = 5'd25;
    localparam logic [4:0] E_TYPE   = 5'd26;

    // Result codes with special meaning.
    localparam logic [4:0] C_END       = 5'd0;
    localparam logic [4:0] C_TYPE      = 5'd1;
    localparam logic [4:0] C_UNKNOWN   = 5'd24;
    localparam logic [4:0] C_TRUNCATED = 5'd25;

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [63:0] field_value;
        logic        is_text;
        logic        price_six_decimals;
        logic [1:0]  protocol_version;
        logic [7:0]  message_kind;
        logic        last_of_message;
    } out_item_t;

    // Classified byte passed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       eom;
        logic       parse;
        logic [2:0] kind;
        logic [4:0] code;
        logic [4:0] size;
        logic       first_of_field;
        logic       field_done;
        logic       eom_ok;
        logic       eom_body;
        logic       big;
        logic       ver2;
        logic [7:0] msg_kind;
        logic [7:0] type_kind;
    } op_t;

    typedef struct packed {
        logic [4:0] code;
        logic [4:0] size_std;
        logic [4:0] size_big;
        logic [2:0] kind;
    } entry_t;

    function automatic entry_t entry_of(input logic [4:0] e);
        entry_t r;
        case (e)
            5'd1:  r = '{5'd4, 5'd1, 5'd1, K_TEXT};
            5'd2:  r = '{5'd5, 5'd6, 5'd6, K_TEXT};
            5'd3:  r = '{5'd6, 5'd1, 5'd1, K_TEXT};
            5'd4:  r = '{5'd7, 5'd1, 5'd1, K_TEXT};
            5'd5:  r = '{5'd8, 5'd6, 5'd6, K_TEXT};
            5'd6:  r = '{5'd9, 5'd1, 5'd1, K_TEXT};
            5'd7:  r = '{5'd10, 5'd1, 5'd1, K_TEXT};
            5'd8:  r = '{5'd11, 5'd1, 5'd1, K_TEXT};
            5'd9:  r = '{5'd12, 5'd4, 5'd4, K_TEXT};
            5'd10: r = '{5'd13, 5'd9, 5'd9, K_N32};
            5'd11: r = '{5'd14, 5'd1, 5'd1, K_TEXT};
            5'd12: r = '{5'd15, 5'd6, 5'd10, K_N32};
            5'd13: r = '{5'd16, 5'd10, 5'd19, K_PRICE};
            5'd14: r = '{5'd17, 5'd4, 5'd4, K_TEXT};
            5'd15: r = '{5'd18, 5'd6, 5'd10, K_N32};
            5'd16: r = '{5'd19, 5'd9, 5'd9, K_N64};
            5'd17: r = '{5'd20, 5'd1, 5'd1, K_TEXT};
            5'd18: r = '{5'd21, 5'd10, 5'd19, K_PRICE};
            5'd19: r = '{5'd22, 5'd6, 5'd10, K_N32};
            5'd20: r = '{5'd23, 5'd1, 5'd1, K_TEXT};
            5'd21: r = '{5'd0, 5'd9, 5'd9, K_SKIP};
            5'd22: r = '{5'd24, 5'd0, 5'd0, K_BODY};
            5'd23: r = '{5'd3, 5'd5, 5'd5, K_N32};
            5'd24: r = '{5'd2, 5'd3, 5'd3, K_N32};
            5'd25: r = '{5'd2, 5'd8, 5'd8, K_N32};
            5'd26: r = '{5'd1, 5'd1, 5'd1, K_TYPE};
            default: r = '{5'd0, 5'd0, 5'd0, K_SKIP};
        endcase
        return r;
    endfunction

    // Layout row of a message type.
    function automatic logic [4:0] layout_row(input logic [7:0] k, input logic v2);
        logic [4:0] r;
        case (k)
            "S": r = 5'd1;
            "R": r = 5'd2;
            "H": r = 5'd3;
            "A", "a": r = v2 ? 5'd5 : 5'd4;
            "F": r = 5'd6;
            "E", "e": r = 5'd7;
            "C": r = 5'd8;
            "X", "x": r = 5'd9;
            "D": r = 5'd10;
            "P", "p": r = 5'd11;
            "Q": r = 5'd12;
            "B": r = 5'd13;
            "I": r = 5'd14;
            "T": r = v2 ? 5'd0 : 5'd15;
            "M": r = v2 ? 5'd0 : 5'd16;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // Entry at position li of layout row.
    function automatic logic [4:0] layout_entry(input logic [4:0] row, input logic [2:0] li);
        logic [4:0] r;
        r = E_NONE;
        case (row)
            5'd0:  if (li == 3'd0) r = 5'd22;
            5'd1:  if (li == 3'd0) r = 5'd1;
            5'd2:  case (li) 3'd0: r = 5'd2; 3'd1: r = 5'd3; 3'd2: r = 5'd4;
                       3'd3: r = 5'd5; 3'd4: r = 5'd6; default: r = E_NONE; endcase
            5'd3:  case (li) 3'd0: r = 5'd2; 3'd1: r = 5'd7; 3'd2: r = 5'd8;
                       3'd3: r = 5'd9; default: r = E_NONE; endcase
            5'd4, 5'd5, 5'd6, 5'd11:
                case (li) 3'd0: r = 5'd10; 3'd1: r = 5'd11; 3'd2: r = 5'd12;
                    3'd3: r = 5'd2; 3'd4: r = 5'd13;
                    3'd5: r = (row == 5'd5) ? 5'd17 : (row == 5'd6) ? 5'd14 :
                              (row == 5'd11) ? 5'd16 : E_NONE;
                    default: r = E_NONE; endcase
            5'd7:  case (li) 3'd0: r = 5'd10; 3'd1: r = 5'd15; 3'd2: r = 5'd16;
                       default: r = E_NONE; endcase
            5'd8:  case (li) 3'd0: r = 5'd10; 3'd1: r = 5'd15; 3'd2: r = 5'd16;
                       3'd3: r = 5'd17; 3'd4: r = 5'd18; default: r = E_NONE; endcase
            5'd9:  case (li) 3'd0: r = 5'd10; 3'd1: r = 5'd19; default: r = E_NONE; endcase
            5'd10: case (li) 3'd0: r = 5'd10; 3'd1: r = 5'd21; default: r = E_NONE; endcase
            5'd12: case (li) 3'd0: r = 5'd12; 3'd1: r = 5'd2; 3'd2: r = 5'd13;
                       3'd3: r = 5'd16; 3'd4: r = 5'd20; default: r = E_NONE; endcase
            5'd13: if (li == 3'd0) r = 5'd16;
            5'd14: case (li) 3'd0: r = 5'd2; 3'd1: r = 5'd20; default: r = E_NONE; endcase
            5'd15: if (li == 3'd0) r = 5'd23;
            5'd16: if (li == 3'd0) r = 5'd24;
            default: r = E_NONE;
        endcase
        return r;
    endfunction

    // Entry expected at a field index.
    function automatic logic [4:0] cur_entry(input logic [3:0] fi, input logic v2,
                                             input logic [7:0] k);
        logic [3:0] hdr;
        logic [3:0] li;
        logic [4:0] r;
        hdr = v2 ? 4'd2 : 4'd1;
        li  = fi - hdr;
        if (v2 && fi == 4'd0) r = E_STAMP2;
        else if (fi == hdr - 4'd1) r = E_TYPE;
        else if (li >= 4'd7) r = E_NONE;
        else r = layout_entry(layout_row(k, v2), li[2:0]);
        return r;
    endfunction

    function automatic logic is_big(input logic [7:0] k);
        return (k == "a") || (k == "p") || (k == "e") || (k == "x");
    endfunction

endpackage
`default_nettype wire

FILE: src/mfp_front.sv
// Front part: tracks message layout and classifies each accepted byte.
`default_nettype none
module mfp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             ext_en,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mfp_pkg::in_item_t in_item,
    output logic                  op_valid,
    input  wire logic             op_ready,
    output mfp_pkg::op_t          op
);
    import mfp_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic             ver2_reg;
    logic [7:0]       kind_reg;
    logic             big_reg;
    logic [3:0]       fidx_reg;
    logic [4:0]       seen_reg;

    logic             acc;
    logic             first;
    logic             ver2_c;
    logic [7:0]       kind_c;
    logic [3:0]       fidx_c;
    logic [4:0]       seen_c;
    logic             parse;
    logic [4:0]       e;
    entry_t           d;
    logic [4:0]       size;
    logic [4:0]       seen_inc;
    logic             done;
    logic [7:0]       tk;
    logic             big_n;
    logic [7:0]       kind_n;
    logic [3:0]       fidx_n;
    logic [4:0]       e_after;

    assign in_ready = op_ready;
    assign op_valid = in_valid;
    assign acc      = in_valid && in_ready;

    // Classification of the byte against the current layout position.
    always_comb
    begin
        first  = (pos_reg == '0);
        parse  = (pos_reg < POS_W'(MAX_MESSAGE_BYTES));
        ver2_c = first ? (in_item.data_byte >= ASCII_ZERO && in_item.data_byte <= ASCII_NINE)
                       : ver2_reg;
        kind_c = first ? 8'd0 : kind_reg;
        fidx_c = first ? 4'd0 : fidx_reg;
        seen_c = first ? 5'd0 : seen_reg;
        e      = parse ? cur_entry(fidx_c, ver2_c, kind_c) : E_NONE;
        d      = entry_of(e);
        size   = (big_reg && !first) ? d.size_big : d.size_std;
        seen_inc = seen_c + 5'd1;
        tk     = in_item.data_byte;
        if (is_big(tk) && (!ver2_c || !ext_en))
            tk = 8'd0;
        kind_n = kind_c;
        big_n  = big_reg && !first;
        done   = 1'b0;
        if (e != E_NONE && d.kind == K_TYPE)
        begin
            kind_n = tk;
            big_n  = is_big(tk);
            done   = 1'b1;
        end
        else if (e != E_NONE && d.kind != K_BODY)
            done = (seen_inc >= size);
        fidx_n = (done && fidx_c < 4'd15) ? fidx_c + 4'd1 : fidx_c;
        e_after = cur_entry(fidx_n, ver2_c, kind_n);

        op.data_byte      = in_item.data_byte;
        op.eom            = in_item.end_of_message;
        op.parse          = (e != E_NONE);
        op.kind           = d.kind;
        op.code           = d.code;
        op.size           = size;
        op.first_of_field = first || (seen_c == 5'd0);
        op.field_done     = done;
        op.eom_ok         = (e_after == E_NONE) || (e_after == E_BODY);
        op.eom_body       = (e_after == E_BODY);
        op.big            = big_n;
        op.ver2           = ver2_c;
        op.msg_kind       = kind_n;
        op.type_kind      = in_item.data_byte;
    end

    // Layout position registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            ver2_reg <= 1'b0;
            kind_reg <= 8'd0;
            big_reg  <= 1'b0;
            fidx_reg <= 4'd0;
            seen_reg <= 5'd0;
        end
        else if (acc)
        begin
            if (in_item.end_of_message)
            begin
                pos_reg  <= '0;
                ver2_reg <= 1'b0;
                kind_reg <= 8'd0;
                big_reg  <= 1'b0;
                fidx_reg <= 4'd0;
                seen_reg <= 5'd0;
            end
            else
            begin
                if (parse)
                    pos_reg <= pos_reg + POS_W'(1);
                ver2_reg <= ver2_c;
                kind_reg <= kind_n;
                big_reg  <= big_n;
                fidx_reg <= fidx_n;
                // A body keeps one running field, so only its first byte starts it.
                if (done)
                    seen_reg <= 5'd0;
                else if (e != E_NONE && d.kind == K_BODY)
                    seen_reg <= 5'd1;
                else if (e != E_NONE)
                    seen_reg <= seen_inc;
                else
                    seen_reg <= seen_c;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/mfp_queue.sv
// Two-entry queue of classified bytes between the front and back parts.
`default_nettype none
module mfp_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_valid,
    output logic             wr_ready,
    input  wire mfp_pkg::op_t wr_data,
    output logic             rd_valid,
    input  wire logic        rd_ready,
    output mfp_pkg::op_t     rd_data
);
    import mfp_pkg::*;

    op_t        mem [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       wr;
    logic       rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule
`default_nettype wire

FILE: src/mfp_back.sv
// Back part: accumulates field values and produces result items.
`default_nettype none
`include "market_feed_message_parser_macros.svh"
module mfp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           op_valid,
    output logic                op_ready,
    input  wire mfp_pkg::op_t   op,
    output logic                out_valid,
    input  wire logic           out_ready,
    output mfp_pkg::out_item_t  out_item
);
    import mfp_pkg::*;

    logic [63:0] acc_reg;
    logic        lead_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic        take;
    logic [63:0] acc_base;
    logic        lead_base;
    logic [63:0] acc_n;
    logic        lead_n;
    logic        have;
    out_item_t   res;

    assign op_ready  = !out_valid_reg || out_ready;
    assign take      = op_valid && op_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Field value update and result formation.
    always_comb
    begin
        acc_base  = op.first_of_field ? 64'd0 : acc_reg;
        lead_base = op.first_of_field ? 1'b1 : lead_reg;
        acc_n     = acc_base;
        lead_n    = lead_base;
        if (op.parse)
        begin
            if (op.kind == K_TEXT || op.kind == K_BODY)
                acc_n = {acc_base[55:0], op.data_byte};
            else if (op.kind == K_N32 || op.kind == K_N64 || op.kind == K_PRICE)
            begin
                if (!(lead_base && op.data_byte == ASCII_SPACE))
                begin
                    lead_n = 1'b0;
                    acc_n  = (acc_base << 3) + (acc_base << 1)
                             + {56'd0, op.data_byte} - 64'd48;
                end
            end
        end
        have = 1'b0;
        res  = '0;
        res.protocol_version = op.ver2 ? 2'd2 : 2'd3;
        res.message_kind     = op.msg_kind;
        res.last_of_message  = op.eom;
        if (op.parse && op.field_done)
        begin
            have = 1'b1;
            if (op.kind == K_TYPE)
            begin
                res.field_code  = C_TYPE;
                res.field_value = {56'd0, op.type_kind};
                res.is_text     = 1'b1;
            end
            else if (op.kind != K_SKIP)
            begin
                res.field_code  = op.code;
                res.field_value = (op.kind == K_N32) ? {32'd0, acc_n[31:0]} : acc_n;
                res.is_text     = (op.kind == K_TEXT);
                res.price_six_decimals = (op.kind == K_PRICE) && op.big;
            end
            else
                have = 1'b0;
        end
        if (op.eom)
        begin
            if (!op.eom_ok)
            begin
                res.field_code  = C_TRUNCATED;
                res.field_value = 64'd0;
                res.is_text     = 1'b0;
                res.price_six_decimals = 1'b0;
            end
            else if (!have)
            begin
                res.field_code  = op.eom_body ? C_UNKNOWN : C_END;
                res.field_value = op.eom_body ? acc_n : 64'd0;
                res.is_text     = op.eom_body;
            end
            have = 1'b1;
        end
    end

    // Accumulator and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 64'd0;
            lead_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                acc_reg  <= acc_n;
                lead_reg <= lead_n;
            end
            if (op_ready)
                out_valid_reg <= take && have;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && have)
            out_reg <= res;
    end

    `MFP_ASSERT_IMPL(a_hold_when_stalled,
        (out_valid && !out_ready) |=> (out_valid && $stable(out_reg)))
    `MFP_ASSERT_IMPL(a_eom_always_result,
        (take && op.eom) |=> (out_valid && out_item.last_of_message))
    `MFP_ASSERT_IMPL(a_code_range, out_valid |-> (out_item.field_code <= C_TRUNCATED))
    `MFP_ASSERT_RESET(a_reset_empty, !rst_n |=> !out_valid)

endmodule
`default_nettype wire

FILE: src/market_feed_message_parser.sv
// An accepted byte is stored in the queue; the back part then registers its result.
// One byte per cycle when not stalled; the front part classifies, a two-entry queue
// decouples it from the back part, which accumulates and registers results.
// Reset clears layout state, the queue and the output; extension_enable
// resets to 1.
// Top level of the market feed message parser.
`default_nettype none
module market_feed_message_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mfp_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mfp_pkg::out_item_t      out_item
);
    import mfp_pkg::*;

    logic ext_en_reg;
    logic f_valid;
    logic f_ready;
    op_t  f_op;
    logic q_valid;
    logic q_ready;
    op_t  q_op;

    // Extension enable register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ext_en_reg <= 1'b1;
        else if (cfg_we)
            ext_en_reg <= cfg_data;
    end

    mfp_front u_front (
        .clk(clk), .rst_n(rst_n), .ext_en(ext_en_reg),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
    );

    mfp_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_op),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_op)
    );

    mfp_back u_back (
        .clk(clk), .rst_n(rst_n),
        .op_valid(q_valid), .op_ready(q_ready), .op(q_op),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

endmodule
`default_nettype wire

FILE: sim/market_feed_message_parser_checker.sv
// Checker for the market feed message parser: predicts each result and compares it.
`default_nettype none
module market_feed_message_parser_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire mfp_pkg::in_item_t  in_item,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire mfp_pkg::out_item_t out_item,
    output int                      fail_count,
    output int                      pending_fields
);
    timeunit 1ns;
    timeprecision 1ps;
    import mfp_pkg::*;

    // Predicted parser state.
    logic        ext_on;
    int unsigned msg_pos;
    logic        is_v2;
    logic [7:0]  kind_byte;
    logic        big;
    logic [3:0]  fidx;
    int unsigned fbytes;
    logic [63:0] acc;
    logic        lead_sp;

    out_item_t field_queue[$];

    assign pending_fields = field_queue.size();

    // Layout row of a type byte.
    function automatic int row_of(input logic [7:0] k, input logic v2);
        case (k)
            "S": return 1;
            "R": return 2;
            "H": return 3;
            "A", "a": return v2 ? 5 : 4;
            "F": return 6;
            "E", "e": return 7;
            "C": return 8;
            "X", "x": return 9;
            "D": return 10;
            "P", "p": return 11;
            "Q": return 12;
            "B": return 13;
            "I": return 14;
            "T": return v2 ? 0 : 15;
            "M": return v2 ? 0 : 16;
            default: return 0;
        endcase
    endfunction

    // Field slot expected next; E_NONE once the layout is done.
    function automatic int slot_now();
        int rows[17][7];
        int hdr;
        int li;
        rows = '{'{22, 0, 0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0, 0, 0},
                 '{2, 3, 4, 5, 6, 0, 0}, '{2, 7, 8, 9, 0, 0, 0},
                 '{10, 11, 12, 2, 13, 0, 0}, '{10, 11, 12, 2, 13, 17, 0},
                 '{10, 11, 12, 2, 13, 14, 0}, '{10, 15, 16, 0, 0, 0, 0},
                 '{10, 15, 16, 17, 18, 0, 0}, '{10, 19, 0, 0, 0, 0, 0},
                 '{10, 21, 0, 0, 0, 0, 0}, '{10, 11, 12, 2, 13, 16, 0},
                 '{12, 2, 13, 16, 20, 0, 0}, '{16, 0, 0, 0, 0, 0, 0},
                 '{2, 20, 0, 0, 0, 0, 0}, '{23, 0, 0, 0, 0, 0, 0},
                 '{24, 0, 0, 0, 0, 0, 0}};
        hdr = is_v2 ? 2 : 1;
        if (is_v2 && fidx == 0) return E_STAMP2;
        if (fidx == hdr - 1) return E_TYPE;
        li = fidx - hdr;
        if (li >= 7) return E_NONE;
        return rows[row_of(kind_byte, is_v2)][li];
    endfunction

    function automatic logic big_kind(input logic [7:0] k);
        return k == "a" || k == "p" || k == "e" || k == "x";
    endfunction

    function automatic void start_field();
        fbytes = 0;
        acc = '0;
        lead_sp = 1'b1;
    endfunction

    function automatic void clear_msg();
        msg_pos = 0;
        is_v2 = 1'b0;
        kind_byte = '0;
        big = 1'b0;
        fidx = '0;
        start_field();
    endfunction

    function automatic void next_field();
        if (fidx < 15) fidx++;
        start_field();
    endfunction

    // Parses one byte into the prediction; returns 1 when a non-skipped field completes.
    function automatic logic parse_byte(input logic [7:0] b, ref out_item_t r);
        int codes[27];
        int smalls[27];
        int bigs[27];
        logic [2:0] kinds[27];
        int s;
        int sz;
        codes  = '{0, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19,
                   20, 21, 22, 23, 0, 24, 3, 2, 2, 1};
        smalls = '{0, 1, 6, 1, 1, 6, 1, 1, 1, 4, 9, 1, 6, 10, 4, 6, 9, 1, 10, 6, 1,
                   9, 0, 5, 3, 8, 1};
        bigs   = '{0, 1, 6, 1, 1, 6, 1, 1, 1, 4, 9, 1, 10, 19, 4, 10, 9, 1, 19, 10,
                   1, 9, 0, 5, 3, 8, 1};
        kinds  = '{K_SKIP, K_TEXT, K_TEXT, K_TEXT, K_TEXT, K_TEXT, K_TEXT, K_TEXT,
                   K_TEXT, K_TEXT, K_N32, K_TEXT, K_N32, K_PRICE, K_TEXT, K_N32,
                   K_N64, K_TEXT, K_PRICE, K_N32, K_TEXT, K_SKIP, K_BODY, K_N32,
                   K_N32, K_N32, K_TYPE};
        s = slot_now();
        if (s == E_NONE) return 1'b0;
        if (kinds[s] == K_TYPE) begin
            kind_byte = (big_kind(b) && (!is_v2 || !ext_on)) ? 8'h00 : b;
            big = big_kind(kind_byte);
            r.field_code = C_TYPE;
            r.field_value = {56'd0, b};
            r.is_text = 1'b1;
            r.price_six_decimals = 1'b0;
            next_field();
            return 1'b1;
        end
        if (kinds[s] == K_BODY) begin
            acc = {acc[55:0], b};
            return 1'b0;
        end
        if (kinds[s] == K_TEXT) acc = {acc[55:0], b};
        else if (kinds[s] != K_SKIP && !(lead_sp && b == ASCII_SPACE)) begin
            lead_sp = 1'b0;
            acc = acc * 64'd10 + {56'd0, b} - 64'd48;
        end
        fbytes++;
        sz = big ? bigs[s] : smalls[s];
        if (fbytes < sz) return 1'b0;
        if (kinds[s] == K_SKIP) begin
            next_field();
            return 1'b0;
        end
        r.field_code = 5'(codes[s]);
        r.field_value = (kinds[s] == K_N32) ? {32'd0, acc[31:0]} : acc;
        r.is_text = kinds[s] == K_TEXT;
        r.price_six_decimals = kinds[s] == K_PRICE && big;
        next_field();
        return 1'b1;
    endfunction

    // Works out the result (if any) of one accepted item.
    task automatic predict_byte(input in_item_t it);
        out_item_t r;
        logic have;
        int s;
        r = '0;
        have = 1'b0;
        if (msg_pos < MAX_MESSAGE_BYTES) begin
            if (msg_pos == 0) begin
                clear_msg();
                is_v2 = it.data_byte >= ASCII_ZERO && it.data_byte <= ASCII_NINE;
            end
            msg_pos++;
            have = parse_byte(it.data_byte, r);
        end
        if (it.end_of_message) begin
            s = slot_now();
            if (s == E_NONE || s == E_BODY) begin
                if (!have) begin
                    r.field_code = (s == E_BODY) ? C_UNKNOWN : C_END;
                    r.field_value = (s == E_BODY) ? acc : 64'd0;
                    r.is_text = s == E_BODY;
                    r.price_six_decimals = 1'b0;
                end
            end else begin
                r.field_code = C_TRUNCATED;
                r.field_value = '0;
                r.is_text = 1'b0;
                r.price_six_decimals = 1'b0;
            end
            have = 1'b1;
        end
        if (have) begin
            r.protocol_version = is_v2 ? 2'd2 : 2'd3;
            r.message_kind = kind_byte;
            r.last_of_message = it.end_of_message;
            field_queue.push_back(r);
            if (it.end_of_message) clear_msg();
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h, want %0h", what, got, want);
        fail_count++;
    endtask

    // Compares one accepted result with the oldest prediction.
    task automatic compare_field(input out_item_t got);
        out_item_t want;
        if (field_queue.size() == 0) begin
            report("unexpected item", got.field_code, 0);
            return;
        end
        want = field_queue.pop_front();
        if (got.field_code != want.field_code) report("code", got.field_code, want.field_code);
        if (got.field_value != want.field_value)
            report("value", got.field_value, want.field_value);
        if (got.is_text != want.is_text) report("is_text", got.is_text, want.is_text);
        if (got.price_six_decimals != want.price_six_decimals)
            report("six decimals", got.price_six_decimals, want.price_six_decimals);
        if (got.protocol_version != want.protocol_version)
            report("version", got.protocol_version, want.protocol_version);
        if (got.message_kind != want.message_kind)
            report("kind", got.message_kind, want.message_kind);
        if (got.last_of_message != want.last_of_message)
            report("last", got.last_of_message, want.last_of_message);
    endtask

    initial begin
        fail_count = 0;
        ext_on = 1'b1;
        clear_msg();
    end

    // Sample both channels at each rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) compare_field(out_item);
            if (in_valid && in_ready) predict_byte(in_item);
            if (cfg_we) ext_on = cfg_data;
        end
    end
endmodule
`default_nettype wire

FILE: sim/market_feed_message_parser_test.sv
// Stimulus and verdict for the market feed message parser.
`default_nettype none
module market_feed_message_parser_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mfp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;
    int        fail_count;
    int        pending_fields;
    int        cycles;
    int        send_idle;
    int        recv_stall;

    market_feed_message_parser dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

    market_feed_message_parser_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .fail_count(fail_count), .pending_fields(pending_fields)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Timeout guard.
    initial cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver stalls at the current percentage.
    always @(posedge clk) out_ready <= ($urandom_range(99, 0) >= recv_stall);

    // Sends one byte, holding it until accepted; valid drops only while idling.
    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(99, 0) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{data_byte: b, end_of_message: eom};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    // Digit or space filler; sometimes any byte.
    function automatic logic [7:0] field_byte();
        int p;
        p = $urandom_range(9, 0);
        if (p == 0) return 8'($urandom_range(255, 0));
        if (p == 1) return ASCII_SPACE;
        return ASCII_ZERO + 8'($urandom_range(9, 0));
    endfunction

    // A random message: usually well-formed, sometimes short, long or noise.
    task automatic send_random_message();
        string kinds;
        logic [7:0] k;
        int n;
        int body;
        kinds = "SRHAFECXDPQBITMapexZ";
        if ($urandom_range(19, 0) == 0) begin
            n = $urandom_range(80, 1);
            for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255, 0)), i == n - 1);
            return;
        end
        k = kinds[$urandom_range(kinds.len() - 1, 0)];
        body = $urandom_range(70, 1);
        if ($urandom_range(1, 0)) begin
            for (int i = 0; i < 8; i++) send_byte(field_byte() | 8'h30 & 8'h3f, 1'b0);
            send_byte(k, body == 0);
        end else begin
            send_byte(k, 1'b0);
        end
        if ($urandom_range(3, 0) != 0) body = $urandom_range(48, 1);
        for (int i = 0; i < body; i++) send_byte(field_byte(), i == body - 1);
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_fields != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_ext(input logic v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int idle_set[4];
        int stall_set[4];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b1;
        send_idle = 0;
        recv_stall = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed messages: both versions, big types, unknown, truncated, long.
        write_ext(1'b1);
        send_text("12345678a  12345678S    100    100 999999999999999999");
        send_text("Tabcde");
        send_text("M999");
        send_text("D123456789abcdefghi");
        send_byte(8'hff, 1'b1);
        send_text("A  1234567B   999Z00001  1234567.89");
        send_byte(8'h00, 1'b1);
        send_text("99999999T1");
        send_text("X123456789 12345");
        wait_drained();
        write_ext(1'b0);
        send_text("00000000x123456789999999999");
        send_text("00000000C123456789    99    12345678Y   77");
        for (int i = 0; i < 70; i++) send_byte(8'h80 | i[6:0], i == 69);
        wait_drained();

        // Random phases over idling mixes and both register settings.
        idle_set = '{0, 62, 0, 28};
        stall_set = '{0, 0, 62, 28};
        for (int ph = 0; ph < 8; ph++) begin
            write_ext(ph[0]);
            send_idle = idle_set[ph % 4];
            recv_stall = stall_set[ph % 4];
            for (int m = 0; m < 4; m++) send_random_message();
            wait_drained();
        end
        send_idle = 0;
        recv_stall = 0;
        wait_drained();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

FILE: market_feed_message_parser.f
+incdir+src
src/mfp_pkg.sv
src/mfp_front.sv
src/mfp_queue.sv
src/mfp_back.sv
src/market_feed_message_parser.sv
sim/market_feed_message_parser_checker.sv
sim/market_feed_message_parser_test.sv
